>>> sv/memory_to_memory_alu_machine_macros.svh
// Assertion helpers for the ALU machine.
// Both forms assume a clock named clk; the first also assumes arst_n.
`ifndef MEMORY_TO_MEMORY_ALU_MACHINE_MACROS_SVH
`define MEMORY_TO_MEMORY_ALU_MACHINE_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clk edge outside reset.
`define AMM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define AMM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define AMM_ASSERT(lbl, prop, msg)
`define AMM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> sv/amm_pkg.sv
`default_nettype none

package amm_pkg;

	localparam int WORD_W    = 32;
	localparam int MEM_DEPTH = 256;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int KIND_W    = 3;
	localparam int CNT_W     = $clog2(WORD_W);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [KIND_W-1:0] kind_t;

	// instruction codes
	localparam kind_t K_ADD    = KIND_W'(0);
	localparam kind_t K_SUB    = KIND_W'(1);
	localparam kind_t K_MUL    = KIND_W'(2);
	localparam kind_t K_DIV    = KIND_W'(3);
	localparam kind_t K_MOD    = KIND_W'(4);
	localparam kind_t K_POW    = KIND_W'(5);
	localparam kind_t K_LOAD   = KIND_W'(6);
	localparam kind_t K_REPORT = KIND_W'(7);

	// start request to the divider
	typedef struct packed {
		logic start;
		logic is_mod;
	} div_req_t;

	// start request to the multiply / power unit
	typedef struct packed {
		logic start;
		logic mul_only;
	} pow_req_t;

	// status back from an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_rsp_t;

	// power-on contents of the data memory
	function automatic word_t rst_word(input addr_t a);
		word_t w;
		case (a)
			ADDR_W'(0): w = WORD_W'(4);
			ADDR_W'(1): w = WORD_W'(23);
			ADDR_W'(2): w = WORD_W'(10);
			ADDR_W'(3): w = WORD_W'(5);
			default:    w = '0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> sv/amm_mem.sv
`default_nettype none

module amm_mem (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire amm_pkg::addr_t rd_a_addr,
	input  wire amm_pkg::addr_t rd_b_addr,
	output amm_pkg::word_t      rd_a_data,
	output amm_pkg::word_t      rd_b_data,
	input  wire logic           wr_en,
	input  wire amm_pkg::addr_t wr_addr,
	input  wire amm_pkg::word_t wr_data
);
	import amm_pkg::*;

	word_t                mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;

	word_t mem_a_s1, mem_b_s1;
	word_t dflt_a_s1, dflt_b_s1;
	logic  vld_a_s1, vld_b_s1;

	// storage array, one write and two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		mem_a_s1  <= mem_q[rd_a_addr];
		mem_b_s1  <= mem_q[rd_b_addr];
		dflt_a_s1 <= rst_word(rd_a_addr);
		dflt_b_s1 <= rst_word(rd_b_addr);
	end

	// written-since-reset marks; an unmarked word reads as its reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_a_s1 <= 1'b0;
			vld_b_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			vld_a_s1 <= vld_q[rd_a_addr];
			vld_b_s1 <= vld_q[rd_b_addr];
		end
	end

	assign rd_a_data = vld_a_s1 ? mem_a_s1 : dflt_a_s1;
	assign rd_b_data = vld_b_s1 ? mem_b_s1 : dflt_b_s1;

endmodule

`default_nettype wire

>>> sv/amm_div.sv
`default_nettype none

module amm_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire amm_pkg::div_req_t req,
	input  wire amm_pkg::word_t   a,
	input  wire amm_pkg::word_t   b,
	output amm_pkg::unit_rsp_t    rsp,
	output amm_pkg::word_t        result
);
	import amm_pkg::*;

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             is_mod_q, neg_a_q, neg_quo_q;
	word_t            dvd_q, dvs_q, rem_q;
	word_t            mag_a, mag_b;
	logic [WORD_W:0]  trial;

	assign mag_a = a[WORD_W-1] ? word_t'(-a) : a;
	assign mag_b = b[WORD_W-1] ? word_t'(-b) : b;

	// restoring step: shift in next dividend bit, try to subtract
	assign trial = {rem_q, dvd_q[WORD_W-1]} - {1'b0, dvs_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dvd_q turns into the quotient one bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			is_mod_q  <= req.is_mod;
			neg_a_q   <= a[WORD_W-1];
			neg_quo_q <= a[WORD_W-1] ^ b[WORD_W-1];
			dvd_q     <= mag_a;
			dvs_q     <= mag_b;
			rem_q     <= '0;
		end else if (busy_q) begin
			if (!trial[WORD_W]) begin
				rem_q <= trial[WORD_W-1:0];
				dvd_q <= {dvd_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WORD_W-2:0], dvd_q[WORD_W-1]};
				dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	// truncation toward zero: remainder takes the dividend's sign
	always_comb begin
		if (is_mod_q) begin
			result = neg_a_q ? word_t'(-rem_q) : rem_q;
		end else begin
			result = neg_quo_q ? word_t'(-dvd_q) : dvd_q;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;

endmodule

`default_nettype wire

>>> sv/amm_pow.sv
`default_nettype none

module amm_pow (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire amm_pkg::pow_req_t req,
	input  wire amm_pkg::word_t   a,
	input  wire amm_pkg::word_t   b,
	output amm_pkg::unit_rsp_t    rsp,
	output amm_pkg::word_t        result,
	output logic                  flag
);
	import amm_pkg::*;

	logic  busy_q, done_q, ph_q, flag_q;
	word_t acc_q, sq_q, e_q;
	word_t mx, prod, e_nxt, special;
	logic  neg_exp;

	// one shared multiplier: phase 0 acc*sq, phase 1 sq*sq
	assign mx    = ph_q ? sq_q : acc_q;
	assign prod  = mx * sq_q;
	assign e_nxt = e_q >> 1;

	assign neg_exp = !req.mul_only && b[WORD_W-1];

	// negative exponent: only bases 1 and -1 survive
	always_comb begin
		if (a == WORD_W'(1)) begin
			special = WORD_W'(1);
		end else if (a == '1) begin
			special = b[0] ? '1 : WORD_W'(1);
		end else begin
			special = '0;
		end
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				ph_q <= 1'b0;
				if (neg_exp) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				ph_q <= !ph_q;
				if (ph_q && e_nxt == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// square-and-multiply datapath; a plain multiply runs as exponent one
	always_ff @(posedge clk) begin
		if (req.start) begin
			flag_q <= 1'b0;
			if (req.mul_only) begin
				acc_q <= a;
				sq_q  <= b;
				e_q   <= WORD_W'(1);
			end else if (neg_exp) begin
				acc_q  <= special;
				flag_q <= (a == '0);
			end else begin
				acc_q <= WORD_W'(1);
				sq_q  <= a;
				e_q   <= b;
			end
		end else if (busy_q) begin
			if (!ph_q) begin
				if (e_q[0]) begin
					acc_q <= prod;
				end
			end else begin
				sq_q <= prod;
				e_q  <= e_nxt;
			end
		end
	end

	assign result   = acc_q;
	assign flag     = flag_q;
	assign rsp.busy = busy_q;
	assign rsp.done = done_q;

endmodule

`default_nettype wire

>>> sv/memory_to_memory_alu_machine.sv
`default_nettype none
// Three-address ALU over a 256-word signed 32-bit data memory (reset contents 4, 23, 10, 5,
// then zeros). One instruction is worked at a time: a beat accepted on the input side reads
// both sources, then the old destination word, then executes and writes back, and the
// destination word afterwards leaves on the output side with its status bit. Add, sub,
// load and report are worked in the execute state; mul uses the multiply / power unit,
// div and mod a one bit per cycle restoring divider, and power steps through the exponent
// bits up to its highest set bit, at least one (one shared multiplier alternates multiply and
// square). A zero divisor skips the divider and a negative exponent skips the iteration. The
// next beat is taken once the result sits in the output register, even if it is not yet
// drained; a finished result waits while that register is full.
// The memory needs no clearing pass after reset.
`include "memory_to_memory_alu_machine_macros.svh"

module memory_to_memory_alu_machine (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [amm_pkg::KIND_W-1:0]            kind,
	input  wire logic [amm_pkg::ADDR_W-1:0]            dest_addr,
	input  wire logic [amm_pkg::ADDR_W-1:0]            src_a_addr,
	input  wire logic [amm_pkg::ADDR_W-1:0]            src_b_addr,
	input  wire logic signed [amm_pkg::WORD_W-1:0]     load_value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [amm_pkg::WORD_W-1:0]          dest_value,
	output logic                                       status
);
	import amm_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RDS  = 6'b000010,
		S_RDD  = 6'b000100,
		S_EXEC = 6'b001000,
		S_WAIT = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q;

	kind_t kind_q;
	addr_t dst_q, sa_q, sb_q;
	word_t ldv_q, opa_q, opb_q, res_q;
	logic  st_q, we_q;

	logic  out_valid_q, status_q;
	word_t dest_value_q;

	addr_t rd_a_addr, rd_b_addr;
	word_t rd_a_data, rd_b_data;
	logic  mem_we, out_free, in_fire, is_divmod;

	div_req_t  div_req;
	pow_req_t  pow_req;
	unit_rsp_t div_rsp, pow_rsp;
	word_t     div_res, pow_res;
	logic      pow_flag;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign mem_we    = (state_q == S_FIN) && out_free && we_q;
	assign is_divmod = (kind_q == K_DIV) || (kind_q == K_MOD);

	// read ports: sources first, then the destination on port a
	always_comb begin
		rd_a_addr = sa_q;
		rd_b_addr = sb_q;
		if (state_q == S_RDD) begin
			rd_a_addr = dst_q;
		end
	end

	amm_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data),
		.wr_en     (mem_we),
		.wr_addr   (dst_q),
		.wr_data   (res_q)
	);

	// unit kick-off from the execute state
	always_comb begin
		div_req.start    = (state_q == S_EXEC) && is_divmod && (opb_q != '0);
		div_req.is_mod   = (kind_q == K_MOD);
		pow_req.start    = (state_q == S_EXEC) && ((kind_q == K_MUL) || (kind_q == K_POW));
		pow_req.mul_only = (kind_q == K_MUL);
	end

	amm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.a      (opa_q),
		.b      (opb_q),
		.rsp    (div_rsp),
		.result (div_res)
	);

	amm_pow u_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pow_req),
		.a      (opa_q),
		.b      (opb_q),
		.rsp    (pow_rsp),
		.result (pow_res),
		.flag   (pow_flag)
	);

	// control sequence; write-back and the next read never share a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_RDS;
				S_RDS:  state_q <= S_RDD;
				S_RDD:  state_q <= S_EXEC;
				S_EXEC: begin
					if (div_req.start || pow_req.start) begin
						state_q <= S_WAIT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_WAIT: if (div_rsp.done || pow_rsp.done) state_q <= S_FIN;
				S_FIN:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// instruction and operand registers, result selection
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= kind;
			dst_q  <= dest_addr;
			sa_q   <= src_a_addr;
			sb_q   <= src_b_addr;
			ldv_q  <= load_value;
		end
		if (state_q == S_RDD) begin
			opa_q <= rd_a_data;
			opb_q <= rd_b_data;
		end
		if (state_q == S_EXEC) begin
			// zero divisor: keep old word, flag it
			st_q <= is_divmod && (opb_q == '0);
			we_q <= (kind_q != K_REPORT) && !(is_divmod && (opb_q == '0));
			case (kind_q)
				K_ADD:   res_q <= opa_q + opb_q;
				K_SUB:   res_q <= opa_q - opb_q;
				K_LOAD:  res_q <= ldv_q;
				default: res_q <= rd_a_data;
			endcase
		end
		if (state_q == S_WAIT) begin
			if (div_rsp.done) begin
				res_q <= div_res;
			end else if (pow_rsp.done) begin
				res_q <= pow_res;
				st_q  <= pow_flag;
			end
		end
		if (state_q == S_FIN && out_free) begin
			dest_value_q <= res_q;
			status_q     <= st_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign dest_value = dest_value_q;
	assign status     = status_q;

	`AMM_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "second beat taken while busy")
	`AMM_ASSERT(a_out_from_fin, $rose(out_valid) |-> $past(state_q == S_FIN), "result from wrong state")
	`AMM_ASSERT(a_done_in_wait, (div_rsp.done || pow_rsp.done) |-> (state_q == S_WAIT), "unit done outside wait")
	`AMM_ASSERT(a_one_unit, !(div_rsp.busy && pow_rsp.busy), "divider and power unit both busy")

endmodule

`default_nettype wire
